// File: rtl/contour_saddle_exit_select_macros.svh
// assertion macros for the contour saddle exit selector
// expects i_clk and i_rst_n in the scope of use
`ifndef CONTOUR_SADDLE_EXIT_SELECT_MACROS_SVH
`define CONTOUR_SADDLE_EXIT_SELECT_MACROS_SVH

// property checked on every clock edge out of reset
`define CSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cse assertion failed");

// condition in one cycle implies a result in the next
`define CSE_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("cse sequence assertion failed");

`endif

// File: rtl/cse_pkg.sv
// shared types and constants for the contour saddle exit selector
// no dependencies
package cse_pkg;

    localparam int Q_W       = 17;          // unsigned q1.16 offset
    localparam int DIV_STEPS = 16;
    localparam int SQ_W      = 2 * Q_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int EDGES     = 4;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    // edge order: s = same..next, n = opposite..next, o = opposite..adjacent, a = same..adjacent
    localparam int E_S = 0;
    localparam int E_N = 1;
    localparam int E_O = 2;
    localparam int E_A = 3;

    typedef enum logic [1:0] {
        FACE_NEXT    = 2'd0,
        FACE_ADJ     = 2'd1,
        FACE_UNKNOWN = 2'd2
    } t_face;

    typedef struct packed {
        logic  calc;   // both faces free, exit found from the offsets
        t_face face;   // exit when calc is low
    } t_ctl;

endpackage

// File: rtl/cse_front.sv
// front part: accepts requests, classifies them and forms edge differences
// depends on cse_pkg
module cse_front import cse_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_adjacent_face_used,
    input  logic                          i_next_face_used,
    input  logic signed [VALUE_WIDTH-1:0] i_same_value,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    input  logic signed [VALUE_WIDTH-1:0] i_opposite_value,
    input  logic signed [VALUE_WIDTH-1:0] i_adjacent_value,
    output logic                          o_q_push,
    input  logic                          i_q_full,
    output t_ctl                          o_ctl,
    output logic [EDGES-1:0]              o_zero,
    output logic [EDGES-1:0][VALUE_WIDTH:0] o_un,
    output logic [EDGES-1:0][VALUE_WIDTH:0] o_ud
);

    localparam int DW = VALUE_WIDTH + 1;

    logic signed [VALUE_WIDTH-1:0] r_level;
    logic                          r_v;
    t_ctl                          r_ctl;
    logic [3:0][VALUE_WIDTH-1:0]   r_corner;   // same, next, opposite, adjacent
    t_ctl                          n_ctl;
    logic [EDGES-1:0][1:0]         lo_idx;
    logic [EDGES-1:0][1:0]         hi_idx;

    assign full     = r_v && i_q_full;
    assign o_q_push = r_v;
    assign o_ctl    = r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_valid) begin
            r_level <= i_cfg_data;
        end
    end

    always_comb begin
        n_ctl.calc = !i_adjacent_face_used && !i_next_face_used;
        if (i_adjacent_face_used && i_next_face_used) begin
            n_ctl.face = FACE_UNKNOWN;
        end else if (i_adjacent_face_used) begin
            n_ctl.face = FACE_NEXT;
        end else if (i_next_face_used) begin
            n_ctl.face = FACE_ADJ;
        end else begin
            n_ctl.face = FACE_NEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!full) begin
            r_v <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!full) begin
            r_ctl       <= n_ctl;
            r_corner[0] <= i_same_value;
            r_corner[1] <= i_next_value;
            r_corner[2] <= i_opposite_value;
            r_corner[3] <= i_adjacent_value;
        end
    end

    assign lo_idx[E_S] = 2'd0;
    assign hi_idx[E_S] = 2'd1;
    assign lo_idx[E_N] = 2'd2;
    assign hi_idx[E_N] = 2'd1;
    assign lo_idx[E_O] = 2'd2;
    assign hi_idx[E_O] = 2'd3;
    assign lo_idx[E_A] = 2'd0;
    assign hi_idx[E_A] = 2'd3;

    for (genvar e = 0; e < EDGES; e++) begin : g_edge
        logic [VALUE_WIDTH-1:0] lo;
        logic [VALUE_WIDTH-1:0] hi;
        logic [DW-1:0]          num;
        logic [DW-1:0]          den;

        assign lo  = r_corner[lo_idx[e]];
        assign hi  = r_corner[hi_idx[e]];
        assign num = {r_level[VALUE_WIDTH-1], r_level} - {lo[VALUE_WIDTH-1], lo};
        assign den = {hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo};
        // zero divisor, zero numerator or opposite signs all give offset 0
        assign o_zero[e] = (num == '0) || (den == '0) || (num[DW-1] != den[DW-1]);
        assign o_un[e]   = num[DW-1] ? (~num + 1'b1) : num;
        assign o_ud[e]   = den[DW-1] ? (~den + 1'b1) : den;
    end

endmodule

// File: rtl/cse_queue.sv
// short first-in first-out queue between the front and back parts
// depends on the assertion macro header
`include "contour_saddle_exit_select_macros.svh"
module cse_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == AW'(0) + (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    `CSE_ASSERT(a_count_bound, r_count <= (AW+1)'(DEPTH))
    `CSE_ASSERT(a_no_pop_empty, i_pop |-> !o_empty)
    `CSE_ASSERT_NEXT(a_drain_last, r_count == (AW+1)'(1) && i_pop && !i_push, o_empty)

endmodule

// File: rtl/cse_back.sv
// back part: pipelined restoring dividers, squared lengths and exit choice
// depends on cse_pkg
module cse_back import cse_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_take,
    input  t_ctl                            i_ctl,
    input  logic [EDGES-1:0]                i_zero,
    input  logic [EDGES-1:0][VALUE_WIDTH:0] i_un,
    input  logic [EDGES-1:0][VALUE_WIDTH:0] i_ud,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_exit_face
);

    localparam int DW = VALUE_WIDTH + 1;
    localparam int RW = VALUE_WIDTH + 2;
    localparam int NS = DIV_STEPS + 1;

    logic                              r_v    [NS];
    t_ctl                              r_ctl  [NS];
    logic [EDGES-1:0]                  r_done [NS];
    logic [EDGES-1:0][RW-1:0]          r_rem  [NS];
    logic [EDGES-1:0][Q_W-1:0]         r_q    [NS];
    logic [EDGES-1:0][DW-1:0]          r_ud   [NS];

    logic                              r_sq_v;
    t_ctl                              r_sq_ctl;
    logic [EDGES-1:0][SQ_W-1:0]        r_sq;    // offset squared
    logic [EDGES-1:0][SQ_W-1:0]        r_csq;   // complement squared
    logic                              r_sum_v;
    t_ctl                              r_sum_ctl;
    logic [SUM_W-1:0]                  r_same2next;
    logic [SUM_W-1:0]                  r_next2opp;
    logic [SUM_W-1:0]                  r_opp2adj;
    logic [SUM_W-1:0]                  r_adj2same;
    logic                              r_out_v;
    t_face                             r_out;
    logic                              adv;
    t_face                             n_face;

    // whole pipeline moves when the result slot is free or being taken
    assign adv         = !r_out_v || pop;
    assign o_take      = adv && i_valid;
    assign empty       = !r_out_v;
    assign o_exit_face = r_out;

    // load stage: settle the clamped cases up front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[0] <= i_ctl;
            for (int e = 0; e < EDGES; e++) begin
                r_ud[0][e]  <= i_ud[e];
                r_rem[0][e] <= RW'(i_un[e]);
                if (i_zero[e]) begin
                    r_done[0][e] <= 1'b1;
                    r_q[0][e]    <= '0;
                end else if (i_un[e] >= i_ud[e]) begin
                    r_done[0][e] <= 1'b1;
                    r_q[0][e]    <= ONE_Q16;
                end else begin
                    r_done[0][e] <= 1'b0;
                    r_q[0][e]    <= '0;
                end
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s < NS; s++) begin : g_step
        logic [EDGES-1:0][RW-1:0]  n_rem;
        logic [EDGES-1:0][Q_W-1:0] n_q;

        always_comb begin
            for (int e = 0; e < EDGES; e++) begin
                n_rem[e] = {r_rem[s-1][e][RW-2:0], 1'b0};
                n_q[e]   = {r_q[s-1][e][Q_W-2:0], 1'b0};
                if (r_done[s-1][e]) begin
                    n_rem[e] = r_rem[s-1][e];
                    n_q[e]   = r_q[s-1][e];
                end else if (n_rem[e] >= RW'(r_ud[s-1][e])) begin
                    n_rem[e] = n_rem[e] - RW'(r_ud[s-1][e]);
                    n_q[e][0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (adv) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ctl[s]  <= r_ctl[s-1];
                r_done[s] <= r_done[s-1];
                r_ud[s]   <= r_ud[s-1];
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_sq_v  <= r_v[NS-1];
            r_sum_v <= r_sq_v;
            r_out_v <= r_sum_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_ctl <= r_ctl[NS-1];
            for (int e = 0; e < EDGES; e++) begin
                r_sq[e]  <= r_q[NS-1][e] * r_q[NS-1][e];
                r_csq[e] <= (ONE_Q16 - r_q[NS-1][e]) * (ONE_Q16 - r_q[NS-1][e]);
            end
            r_sum_ctl   <= r_sq_ctl;
            r_same2next <= SUM_W'(r_csq[E_S]) + SUM_W'(r_csq[E_N]);
            r_next2opp  <= SUM_W'(r_sq[E_O]) + SUM_W'(r_sq[E_N]);
            r_opp2adj   <= SUM_W'(r_csq[E_O]) + SUM_W'(r_csq[E_A]);
            r_adj2same  <= SUM_W'(r_sq[E_S]) + SUM_W'(r_sq[E_A]);
            r_out       <= n_face;
        end
    end

    // comparison tree, ties take the second branch
    always_comb begin
        if (!r_sum_ctl.calc) begin
            n_face = r_sum_ctl.face;
        end else if (r_same2next < r_next2opp) begin
            n_face = (r_same2next < r_adj2same) ? FACE_NEXT : FACE_ADJ;
        end else begin
            n_face = (r_next2opp < r_opp2adj) ? FACE_ADJ : FACE_NEXT;
        end
    end

endmodule

// File: rtl/contour_saddle_exit_select.sv
// top level of the contour saddle exit selector
// depends on cse_pkg, cse_front, cse_queue and cse_back
//
//  port group      direction  handshake
//  cfg write       in         i_cfg_valid / o_cfg_ready, i_cfg_data
//  cell request    in         push / full, i_*_face_used, i_*_value
//  exit result     out        empty / pop, o_exit_face
//
// one request per cycle sustained while results are popped; requests pass the front
// register, queue, load stage, 16-stage divider, square, sum and result registers
// reset clears the level register to 0 and empties every stage
// a held result stalls the back pipeline; the 4-entry queue then fills and raises full
module contour_saddle_exit_select import cse_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_adjacent_face_used,
    input  logic                          i_next_face_used,
    input  logic signed [VALUE_WIDTH-1:0] i_same_value,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    input  logic signed [VALUE_WIDTH-1:0] i_opposite_value,
    input  logic signed [VALUE_WIDTH-1:0] i_adjacent_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_exit_face
);

    localparam int DW    = VALUE_WIDTH + 1;
    localparam int QW    = $bits(t_ctl) + EDGES + 2 * EDGES * DW;

    logic                     f_push;
    logic                     q_full;
    logic                     q_empty;
    logic                     q_pop;
    t_ctl                     f_ctl;
    logic [EDGES-1:0]         f_zero;
    logic [EDGES-1:0][DW-1:0] f_un;
    logic [EDGES-1:0][DW-1:0] f_ud;
    logic [QW-1:0]            q_in;
    logic [QW-1:0]            q_out;
    t_ctl                     b_ctl;
    logic [EDGES-1:0]         b_zero;
    logic [EDGES-1:0][DW-1:0] b_un;
    logic [EDGES-1:0][DW-1:0] b_ud;

    assign o_cfg_ready = 1'b1;

    cse_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_data           (i_cfg_data),
        .push                 (push),
        .full                 (full),
        .i_adjacent_face_used (i_adjacent_face_used),
        .i_next_face_used     (i_next_face_used),
        .i_same_value         (i_same_value),
        .i_next_value         (i_next_value),
        .i_opposite_value     (i_opposite_value),
        .i_adjacent_value     (i_adjacent_value),
        .o_q_push             (f_push),
        .i_q_full             (q_full),
        .o_ctl                (f_ctl),
        .o_zero               (f_zero),
        .o_un                 (f_un),
        .o_ud                 (f_ud)
    );

    assign q_in = {f_ctl, f_zero, f_un, f_ud};

    cse_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_zero, b_un, b_ud} = q_out;

    cse_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .o_take      (q_pop),
        .i_ctl       (b_ctl),
        .i_zero      (b_zero),
        .i_un        (b_un),
        .i_ud        (b_ud),
        .empty       (empty),
        .pop         (pop),
        .o_exit_face (o_exit_face)
    );

endmodule

// File: tb/sv/contour_saddle_exit_select_tb.sv
// testbench for the contour saddle exit selector: queue driver, monitor, exit-face predictor
// depends on cse_pkg and contour_saddle_exit_select
`timescale 1ns / 100ps

module contour_saddle_exit_select_tb import cse_pkg::*;;

    localparam int VW = 32;
    localparam int LATENCY = 30;
    localparam longint LIMIT = 600000;

    typedef struct packed {
        logic            adj_used;
        logic            next_used;
        logic signed [VW-1:0] v_same;
        logic signed [VW-1:0] v_next;
        logic signed [VW-1:0] v_opp;
        logic signed [VW-1:0] v_adj;
    } t_cell;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic signed [VW-1:0] i_cfg_data = '0;
    logic                 push = 0;
    logic                 full;
    logic                 i_adjacent_face_used = 0;
    logic                 i_next_face_used = 0;
    logic signed [VW-1:0] i_same_value = '0;
    logic signed [VW-1:0] i_next_value = '0;
    logic signed [VW-1:0] i_opposite_value = '0;
    logic signed [VW-1:0] i_adjacent_value = '0;
    logic                 empty;
    logic                 pop = 0;
    logic [1:0]           o_exit_face;

    contour_saddle_exit_select #(.VALUE_WIDTH(VW)) uut (.*);

    t_cell      cell_q[$];
    t_face      exit_q[$];
    logic signed [VW-1:0] level = '0;
    int         errors = 0;
    longint     cycles = 0;
    bit         drain_hold = 0;   // driver waits for the result queue to drain
    int         hold_cycles = 0;  // long receiver hold-off

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // hold-off counter runs on its own
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles--;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // clamped crossing offset (lvl - a) / (b - a) in q1.16
    function automatic logic [16:0] crossing(input longint lvl, input longint a, input longint b);
        longint num, den, un, ud, r;
        logic [16:0] q;
        num = lvl - a;
        den = b - a;
        if (den == 0 || num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        if (un >= ud) return 17'h10000;
        r = un;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r -= ud;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_face exit_of(input t_cell c, input logic signed [VW-1:0] lv);
        longint s, n, o, a, s2n, n2o, o2a, a2s;
        if (c.adj_used && c.next_used) return FACE_UNKNOWN;
        if (c.adj_used) return FACE_NEXT;
        if (c.next_used) return FACE_ADJ;
        s = crossing(lv, c.v_same, c.v_next);
        n = crossing(lv, c.v_opp, c.v_next);
        o = crossing(lv, c.v_opp, c.v_adj);
        a = crossing(lv, c.v_same, c.v_adj);
        s2n = (65536 - s) * (65536 - s) + (65536 - n) * (65536 - n);
        n2o = o * o + n * n;
        o2a = (65536 - o) * (65536 - o) + (65536 - a) * (65536 - a);
        a2s = s * s + a * a;
        if (s2n < n2o) return (s2n < a2s) ? FACE_NEXT : FACE_ADJ;
        return (n2o < o2a) ? FACE_ADJ : FACE_NEXT;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                exit_q.push_back(exit_of(cell_q.pop_front(), level));
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (!(push && full)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 0;
                end else if (cell_q.size() > 0 && !drain_hold) begin
                    push <= 1;
                    i_adjacent_face_used <= cell_q[0].adj_used;
                    i_next_face_used <= cell_q[0].next_used;
                    i_same_value <= cell_q[0].v_same;
                    i_next_value <= cell_q[0].v_next;
                    i_opposite_value <= cell_q[0].v_opp;
                    i_adjacent_value <= cell_q[0].v_adj;
                end else begin
                    push <= 0;
                end
            end
        end
    end

    // monitor
    int pop_gap = 0;
    bit quiet = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (exit_q.size() == 0) begin
                    report("result with no request waiting");
                end else begin
                    t_face want;
                    want = exit_q.pop_front();
                    if (o_exit_face != want)
                        report($sformatf("exit_face got %0d want %0d", o_exit_face, want));
                end
                pop_gap = quiet ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
            end
            if (hold_cycles > 0) begin
                pop <= 0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 0;
            end else begin
                pop <= 1;
            end
        end
    end

    function automatic logic signed [VW-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 8)) << 16) - 32'sh40000;
            3: return $signed(32'($urandom_range(0, 4095)) - 2048);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        // mostly both faces free so the offset path gets exercised
        c.adj_used = $urandom_range(0, 3) == 0;
        c.next_used = $urandom_range(0, 3) == 0;
        c.v_same = rand_val();
        c.v_next = rand_val();
        c.v_opp = rand_val();
        c.v_adj = rand_val();
        return c;
    endfunction

    task automatic add(input logic au, input logic nu, input int s, input int n,
                       input int o, input int a);
        cell_q.push_back({au, nu, s, n, o, a});
    endtask

    task automatic settle();
        while (cell_q.size() > 0 || push || exit_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_level(input logic signed [VW-1:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        level = v;
        i_cfg_valid <= 0;
    endtask

    initial begin
        logic signed [VW-1:0] levels[5];
        levels = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh18000, -32'sh8000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: face flags, saddle both ways, equal corners, extremes
        add(1, 1, 0, 0, 0, 0);
        add(1, 0, 5, 5, 5, 5);
        add(0, 1, 5, 5, 5, 5);
        add(0, 0, -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000);
        add(0, 0, 32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000);
        add(0, 0, 0, 0, 0, 0);
        add(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add(0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add(0, 0, -32'sh30000, 32'sh10000, -32'sh8000, 32'sh20000);
        add(0, 0, -1, 32'sh7fffffff, -32'sh7fffffff, 1);
        add(0, 0, 3, -1, 2, -7);
        add(1, 1, -1, -1, -1, -1);
        settle();

        for (int p = 0; p < 5; p++) begin
            write_level(levels[p]);
            for (int i = 0; i < 130; i++) cell_q.push_back(rand_cell());
            if (p == 1) begin
                // long receiver hold-off while the sender keeps offering
                hold_cycles = 200;
                quiet = 1;
            end
            if (p == 2) begin
                // sender pauses until every result is back
                while (cell_q.size() > 65) @(posedge i_clk);
                drain_hold = 1;
                while (exit_q.size() > 0 || push) @(posedge i_clk);
                drain_hold = 0;
            end
            settle();
            quiet = 0;
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
